// ===== src/assert_macros.svh =====
// assertion macros shared by the checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/ksc_pkg.sv =====
// package for the k-mer spectrum classifier: types, codes and constants
// no dependencies
package ksc_pkg;
    localparam int MAX_KMER    = 6;
    localparam int MAX_CLASSES = 8;
    localparam int WEIGHT_BITS = 24;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_EOS   = 2'd2;

    localparam logic [0:0] REG_CLASS_COUNT = 1'b0;
    localparam logic [0:0] REG_KMER_LENGTH = 1'b1;

    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_NL = 8'h0A;

    localparam int SCORE_BITS = 32;

    typedef enum logic [1:0] {PH_HEADER, PH_FIRST, PH_BODY} phase_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_ACC, ST_INTER, ST_CMP, ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take;       // latch input word
        logic do_write;   // write table
        logic shift;      // shift base into window
        logic clr_rec;    // clear window and count
        logic start_scan; // reset class counter and set table base
        logic use_inter;  // address intercepts
        logic acc;        // accumulate current class: issue read, then consume
        logic load;       // first k-mer: load instead of add
        logic cmp;        // compare step
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic is_base;
        logic is_gt;
        logic is_end;
        logic is_nl;
        logic kmer_done;  // bases_seen reaches k after shift
        logic last_class;
        logic rd_valid;   // registered read data is being consumed
    } stat_t;

    function automatic logic [2:0] base_code(input logic [7:0] ch, output logic ok);
        ok = 1'b1;
        case (ch)
            8'h41, 8'h61: base_code = 3'd0;
            8'h43, 8'h63: base_code = 3'd1;
            8'h47, 8'h67: base_code = 3'd2;
            8'h54, 8'h74: base_code = 3'd3;
            default:
            begin
                base_code = 3'd0;
                ok = 1'b0;
            end
        endcase
    endfunction
endpackage

// ===== src/ksc_if.sv =====
// valid/ready channel interfaces for the classifier
// depends on nothing
interface ksc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] weight_addr;
    logic signed [23:0] weight_value;
    logic [7:0]  stream_byte;
    modport source (output valid, cmd, weight_addr, weight_value, stream_byte, input ready);
    modport sink (input valid, cmd, weight_addr, weight_value, stream_byte, output ready);
endinterface

interface ksc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] class_id;
    modport source (output valid, class_id, input ready);
    modport sink (input valid, class_id, output ready);
endinterface

interface ksc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ksc_ctrl.sv =====
// controller state machine for the classifier
// depends on ksc_pkg
module ksc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_busy,
    output logic          out_load,
    output logic          out_zero,
    output ksc_pkg::cmd_t cmd,
    input  ksc_pkg::stat_t st
);
    import ksc_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_HEADER;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

    // ST_LOAD is the decode cycle of the latched word
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        first_next = first_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready) state_next = ST_LOAD;
            ST_LOAD:
            begin
                state_next = ST_IDLE;
                case (st.cmd)
                    CMD_EOS:
                        if (phase_reg == PH_FIRST) state_next = ST_OUT;
                        else if (phase_reg == PH_BODY) state_next = ST_INTER;
                        else phase_next = PH_HEADER;
                    CMD_BYTE:
                        case (phase_reg)
                            PH_HEADER:
                                if (st.is_nl) phase_next = PH_FIRST;
                            PH_FIRST:
                                if (st.is_gt) state_next = ST_OUT;
                                else if (st.is_base && st.kmer_done)
                                begin
                                    state_next = ST_ACC;
                                    first_next = 1'b1;
                                    phase_next = PH_BODY;
                                end
                            PH_BODY:
                                if (st.is_end) state_next = ST_INTER;
                                else if (st.is_base) begin state_next = ST_ACC; first_next = 1'b0; end
                            default: phase_next = PH_HEADER;
                        endcase
                    default: ;
                endcase
            end
            ST_ACC:
                if (st.rd_valid && st.last_class) state_next = ST_IDLE;
            ST_INTER:
                if (st.rd_valid && st.last_class) state_next = ST_CMP;
            ST_CMP:
                if (st.last_class) state_next = ST_OUT;
            ST_OUT:
                if (!out_busy) begin state_next = ST_IDLE; phase_next = PH_HEADER; end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        out_zero = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_LOAD:
            begin
                cmd.do_write = (st.cmd == CMD_WRITE);
                cmd.start_scan = 1'b1;
                cmd.use_inter = (st.cmd == CMD_EOS) || st.is_end;
                if (st.cmd == CMD_BYTE && phase_reg == PH_HEADER && st.is_nl) cmd.clr_rec = 1'b1;
                if (st.cmd == CMD_BYTE && phase_reg != PH_HEADER && st.is_base && !st.is_gt
                    && !(phase_reg == PH_BODY && st.is_end))
                    cmd.shift = 1'b1;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                cmd.load = first_reg;
            end
            ST_INTER:
            begin
                cmd.acc = 1'b1;
                cmd.use_inter = 1'b1;
            end
            ST_CMP:
                cmd.cmp = 1'b1;
            ST_OUT:
            begin
                out_load = !out_busy;
                out_zero = (phase_reg == PH_FIRST);
                cmd.clr_rec = !out_busy;
                cmd.start_scan = !out_busy;
            end
            default: ;
        endcase
    end
endmodule

// ===== src/ksc_datapath.sv =====
// datapath: weight memory, k-mer window, score registers and arg-max
// depends on ksc_pkg
module ksc_datapath
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    in_cmd,
    input  logic [15:0]   in_addr,
    input  logic [23:0]   in_value,
    input  logic [7:0]    in_byte,
    input  logic [3:0]    class_count,
    input  logic [2:0]    kmer_length,
    input  ksc_pkg::cmd_t cmd,
    output ksc_pkg::stat_t st,
    output logic [3:0]    best_id
);
    import ksc_pkg::*;

    localparam int DEPTH = (1 << (2 * MAX_KMER)) * MAX_CLASSES + MAX_CLASSES;
    localparam int AW = $clog2(DEPTH + 1);
    localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int KW = 2 * MAX_KMER;
    localparam int BW = $clog2(MAX_KMER + 1);

    logic signed [WEIGHT_BITS-1:0] mem [DEPTH];
    logic signed [WEIGHT_BITS-1:0] rdata_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [23:0] value_reg;
    logic [7:0]  byte_reg;
    logic [KW-1:0] win_reg;
    logic [BW-1:0] seen_reg;
    logic [CW:0]   cls_reg;   // class counter for read address
    logic [CW:0]   rcls_reg;  // class of the registered read data
    logic          rvalid_reg;
    logic signed [SCORE_BITS-1:0] score_reg [MAX_CLASSES];
    logic [CW-1:0] best_reg;
    logic [AW-1:0] base_reg;

    // effective register values
    logic [CW:0] nc;
    logic [3:0]  k;
    always_comb
    begin
        if (class_count == 4'd0) nc = (CW+1)'(1);
        else if (32'(class_count) > MAX_CLASSES) nc = (CW+1)'(MAX_CLASSES);
        else nc = (CW+1)'(class_count);
        if (kmer_length == 3'd0) k = 4'd1;
        else if (32'(kmer_length) > MAX_KMER) k = 4'(MAX_KMER);
        else k = {1'b0, kmer_length};
    end

    logic [KW-1:0] kmask;
    assign kmask = KW'((64'd1 << (2 * k)) - 64'd1);

    logic ok;
    logic [2:0] code;
    always_comb
    begin
        code = base_code(byte_reg, ok);
    end

    logic [KW-1:0] win_new;
    assign win_new = ((win_reg << 2) | KW'(code[1:0])) & kmask;

    always_comb
    begin
        st.cmd = cmd_reg;
        st.is_base = ok;
        st.is_gt = (byte_reg == CH_GT);
        st.is_end = (byte_reg == CH_GT) || (byte_reg == CH_PLUS) || (byte_reg == CH_AT);
        st.is_nl = (byte_reg == CH_NL);
        st.kmer_done = (32'(seen_reg) + 1 >= 32'(k));
        st.last_class = (rcls_reg + 1'b1 >= nc);
        st.rd_valid = rvalid_reg;
    end

    // table base: window (or 4^k) times classes
    logic [AW-1:0] base_next;
    always_comb
    begin
        logic [AW:0] idx;
        idx = cmd.use_inter ? (AW+1)'(64'd1 << (2 * k)) : (AW+1)'(cmd.shift ? win_new : win_reg);
        base_next = AW'(idx * (AW+1)'(nc));
    end

    logic [AW-1:0] raddr;
    assign raddr = base_reg + AW'(cls_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.do_write && 32'(addr_reg) < DEPTH)
            mem[AW'(addr_reg)] <= WEIGHT_BITS'(value_reg);
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            addr_reg <= in_addr;
            value_reg <= in_value;
            byte_reg <= in_byte;
        end
        if (cmd.start_scan) base_reg <= base_next;
    end

    // saturating add of registered read data, doubled except for intercepts
    logic signed [SCORE_BITS+1:0] sum;
    logic signed [SCORE_BITS-1:0] sat;
    logic signed [SCORE_BITS+1:0] addend;
    logic signed [SCORE_BITS-1:0] cur;
    always_comb
    begin
        cur = score_reg[rcls_reg[CW-1:0]];
        addend = (SCORE_BITS+2)'(rdata_reg);
        if (!cmd.use_inter) addend = addend <<< 1;
        sum = (SCORE_BITS+2)'(cur) + addend;
        if (sum > (SCORE_BITS+2)'(32'sh7fffffff)) sat = 32'sh7fffffff;
        else if (sum < -(SCORE_BITS+2)'(34'sh080000000)) sat = 32'sh80000000;
        else sat = sum[SCORE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= '0;
            win_reg <= '0;
            seen_reg <= '0;
            cls_reg <= '0;
            rcls_reg <= '0;
            rvalid_reg <= 1'b0;
            best_reg <= '0;
            for (int i = 0; i < MAX_CLASSES; i++) score_reg[i] <= '0;
        end
        else
        begin
            if (cmd.take) cmd_reg <= in_cmd;
            if (cmd.clr_rec)
            begin
                win_reg <= '0;
                seen_reg <= '0;
            end
            else if (cmd.shift)
            begin
                win_reg <= win_new;
                if (seen_reg < BW'(MAX_KMER)) seen_reg <= seen_reg + 1'b1;
            end
            if (cmd.start_scan)
            begin
                cls_reg <= '0;
                rvalid_reg <= 1'b0;
                rcls_reg <= '0;
                best_reg <= '0;
            end
            else if (cmd.acc)
            begin
                // one read in flight: issue, then consume
                if (rvalid_reg)
                begin
                    score_reg[rcls_reg[CW-1:0]] <= cmd.load ? SCORE_BITS'(rdata_reg) : sat;
                    rvalid_reg <= 1'b0;
                    cls_reg <= (rcls_reg + 1'b1 >= nc) ? '0 : cls_reg + 1'b1;
                    rcls_reg <= (rcls_reg + 1'b1 >= nc) ? '0 : rcls_reg + 1'b1;
                end
                else
                    rvalid_reg <= 1'b1;
            end
            else if (cmd.cmp)
            begin
                if (rcls_reg != '0 && score_reg[rcls_reg[CW-1:0]] > score_reg[best_reg])
                    best_reg <= rcls_reg[CW-1:0];
                rcls_reg <= (rcls_reg + 1'b1 >= nc) ? '0 : rcls_reg + 1'b1;
            end
        end
    end

    assign best_id = 4'(best_reg) + 4'd1;
endmodule

// ===== src/kmer_spectrum_classifier.sv =====
// k-mer spectrum classifier: a record takes a decode step per word; each k-mer base adds one table
// read then one accumulate per class; at record end the intercepts are read and accumulated per
// class, the scores compared and the output loaded; an early end goes straight to the output;
// output stalls hold the output state
// the weight memory port is the limit: one read in flight
// reset: scores, window and phase clear; weight table undefined until written
module kmer_spectrum_classifier
(
    input logic clk,
    input logic rst_n,
    ksc_in_if.sink    in_ch,
    ksc_out_if.source out_ch,
    ksc_cfg_if.sink   cfg
);
    import ksc_pkg::*;

    logic [3:0] class_count_reg;
    logic [2:0] kmer_length_reg;
    logic       out_valid_reg;
    logic [3:0] out_id_reg;
    cmd_t       cmd;
    stat_t      st;
    logic       out_load, out_zero;
    logic [3:0] best_id;

    // configuration always accepted
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= 4'd1;
            kmer_length_reg <= 3'd6;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_CLASS_COUNT) class_count_reg <= cfg.data;
            else kmer_length_reg <= cfg.data[2:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_id_reg <= '0;
        end
        else
        begin
            if (out_ch.ready) out_valid_reg <= 1'b0;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_id_reg <= out_zero ? 4'd0 : best_id;
            end
        end
    end
    assign out_ch.valid = out_valid_reg;
    assign out_ch.class_id = out_id_reg;

    ksc_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_busy(out_valid_reg && !out_ch.ready), .out_load(out_load), .out_zero(out_zero),
        .cmd(cmd), .st(st)
    );

    ksc_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .in_cmd(in_ch.cmd), .in_addr(in_ch.weight_addr),
        .in_value(in_ch.weight_value), .in_byte(in_ch.stream_byte),
        .class_count(class_count_reg), .kmer_length(kmer_length_reg),
        .cmd(cmd), .st(st), .best_id(best_id)
    );
endmodule

// ===== src/ksc_checker.sv =====
// port-level checker for the classifier, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module ksc_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [3:0] class_id
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(class_id))
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_IMPL(a_id_range, clk, rst_n, out_valid, class_id <= 4'd8)
endmodule

bind kmer_spectrum_classifier ksc_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .class_id(out_ch.class_id)
);
